/* hdl/chgw_pkg.sv */
package chgw_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 6;                 // vertex_index port width
  localparam int DIFF_W  = COORD_W + 1;       // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;        // one cross-product term
  localparam int CROSS_W = PROD_W + 1;        // difference of the two terms
  localparam int MIN_HULL_PTS = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  // orientation test result, one beat per scanned point
  typedef struct packed {
    logic   valid;
    logic   left;    // current vertex strictly left of line point->candidate
    point_t pt;      // scanned point, carried along with the test
  } cross_res_t;

endpackage

/* hdl/chgw_store.sv */
module chgw_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  chgw_pkg::point_t   wdata,
  input  logic [AW-1:0]      raddr,
  output chgw_pkg::point_t   rdata
);

  chgw_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/chgw_cross.sv */
module chgw_cross (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  chgw_pkg::point_t     pt,
  input  chgw_pkg::point_t     cur,
  input  chgw_pkg::point_t     cand,
  output chgw_pkg::cross_res_t res
);

  logic signed [chgw_pkg::DIFF_W-1:0]  abx, aby, acx, acy;
  logic signed [chgw_pkg::PROD_W-1:0]  p_ab, p_ba;
  logic signed [chgw_pkg::CROSS_W-1:0] cross_val;
  logic                                s1_valid, s2_valid;
  chgw_pkg::point_t                    s1_pt, s2_pt;

  // stage 1: differences, stage 2: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
    abx   <= chgw_pkg::DIFF_W'(cand.x) - chgw_pkg::DIFF_W'(pt.x);
    aby   <= chgw_pkg::DIFF_W'(cand.y) - chgw_pkg::DIFF_W'(pt.y);
    acx   <= chgw_pkg::DIFF_W'(cur.x)  - chgw_pkg::DIFF_W'(pt.x);
    acy   <= chgw_pkg::DIFF_W'(cur.y)  - chgw_pkg::DIFF_W'(pt.y);
    s1_pt <= pt;
    p_ab  <= abx * acy;
    p_ba  <= aby * acx;
    s2_pt <= s1_pt;
  end

  assign cross_val = chgw_pkg::CROSS_W'(p_ab) - chgw_pkg::CROSS_W'(p_ba);

  always_comb begin
    res.valid = s2_valid;
    res.left  = !cross_val[chgw_pkg::CROSS_W-1] && (cross_val != '0);
    res.pt    = s2_pt;
  end

endmodule

/* hdl/convex_hull_gift_wrap.sv */
// Load: one point per beat; busy stays low while loading.
// Hull pass after the beat with last_point: a leftmost search, then one scan
// of all n stored points per hull vertex (n = stored points); each scanned
// point goes through store read, difference stage and multiply stage before the next is read.
// Each vertex is strobed on valid for one cycle; the receiver cannot stall.
// rst (synchronous, active high) clears the point count and the sequencer.
module convex_hull_gift_wrap #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  chgw_pkg::coord_t    px,
  input  chgw_pkg::coord_t    py,
  input  logic                last_point,
  output logic                busy,
  output logic                valid,
  output logic [chgw_pkg::IDX_W-1:0] vertex_index,
  output chgw_pkg::coord_t    vx,
  output chgw_pkg::coord_t    vy,
  output logic                last_vertex
);

  // index into the store, and a count that can hold MAX_POINTS itself
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    IDLE,     // loading points
    FIND,     // stream the store, track leftmost point
    SEED,     // leftmost becomes the first hull vertex
    CAND_RD,  // read initial candidate (cur+1) mod n
    CAND_WT,  // latch candidate, launch scan of point 0
    SCAN,     // one orientation test per stored point
    EMIT      // put the vertex out, step to the winner
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;      // points stored in the current set
  logic [CW-1:0]     n_pts;      // size of the set being wrapped
  logic [CW-1:0]     n_new;
  logic [CW-1:0]     rd_ptr;     // leftmost search read pointer
  logic              dv;         // leftmost search data valid
  logic [IW-1:0]     didx;
  logic [IW-1:0]     start_idx;
  chgw_pkg::point_t  min_pt;
  logic [IW-1:0]     cur;
  chgw_pkg::point_t  cur_pt;
  logic [IW-1:0]     cand;
  chgw_pkg::point_t  cand_pt;
  logic [IW-1:0]     cand_nx;
  logic [CW-1:0]     cur_inc;
  logic [IW-1:0]     scan_i;
  logic              scan_last;
  logic [CW-1:0]     emitted;
  logic [CW-1:0]     emitted_next;
  logic              hull_done;
  logic              rd_valid;   // store data is a scan point
  logic              issue;
  logic              accept;
  logic              room;
  logic [IW-1:0]     raddr;
  chgw_pkg::point_t  wdata;
  chgw_pkg::point_t  rdata;
  chgw_pkg::cross_res_t cres;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign room   = (count < CW'(MAX_POINTS));   // full store drops the point
  assign n_new  = room ? count + CW'(1) : count;

  assign wdata.x = px;
  assign wdata.y = py;

  // next candidate wraps at n, not at the store depth
  assign cur_inc = CW'(cur) + CW'(1);
  assign cand_nx = (cur_inc == n_pts) ? '0 : cur_inc[IW-1:0];

  assign scan_last    = (CW'(scan_i) == n_pts - CW'(1));
  assign emitted_next = emitted + CW'(1);
  // march closes at the start, or is cut off on degenerate sets
  assign hull_done    = (cand == start_idx) || (emitted_next == CW'(MAX_POINTS));

  // store read address and scan launch
  always_comb begin
    raddr = '0;
    issue = 1'b0;
    case (state)
      FIND:    raddr = rd_ptr[IW-1:0];
      CAND_RD: raddr = cand_nx;
      CAND_WT: issue = 1'b1;             // point 0
      SCAN: begin
        if (cres.valid && !scan_last) begin
          raddr = scan_i + IW'(1);
          issue = 1'b1;
        end
      end
      default: raddr = '0;
    endcase
  end

  chgw_store #(
    .DEPTH (MAX_POINTS),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (accept && room),
    .waddr (count[IW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  chgw_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .pt       (rdata),
    .cur      (cur_pt),
    .cand     (cand_pt),
    .res      (cres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      valid    <= 1'b0;
      dv       <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      valid    <= 1'b0;
      dv       <= 1'b0;
      rd_valid <= issue;
      case (state)
        IDLE: begin
          if (accept) begin
            if (last_point) begin
              count <= '0;
              if (n_new >= CW'(chgw_pkg::MIN_HULL_PTS)) begin
                n_pts  <= n_new;
                rd_ptr <= '0;
                state  <= FIND;
              end
            end else if (room) begin
              count <= count + CW'(1);
            end
          end
        end
        FIND: begin
          if (rd_ptr < n_pts) begin
            rd_ptr <= rd_ptr + CW'(1);
            dv     <= 1'b1;
            didx   <= rd_ptr[IW-1:0];
          end
          if (dv) begin
            // strict compare keeps the lowest index on ties
            if (didx == '0 || rdata.x < min_pt.x) begin
              start_idx <= didx;
              min_pt    <= rdata;
            end
            if (CW'(didx) == n_pts - CW'(1)) begin
              state <= SEED;
            end
          end
        end
        SEED: begin
          cur     <= start_idx;
          cur_pt  <= min_pt;
          emitted <= '0;
          state   <= CAND_RD;
        end
        CAND_RD: begin
          cand  <= cand_nx;
          state <= CAND_WT;
        end
        CAND_WT: begin
          cand_pt <= rdata;
          scan_i  <= '0;
          state   <= SCAN;
        end
        SCAN: begin
          if (cres.valid) begin
            if (cres.left) begin
              cand    <= scan_i;
              cand_pt <= cres.pt;
            end
            if (scan_last) begin
              state <= EMIT;
            end else begin
              scan_i <= scan_i + IW'(1);
            end
          end
        end
        EMIT: begin
          valid        <= 1'b1;
          vertex_index <= chgw_pkg::IDX_W'(cur);
          vx           <= cur_pt.x;
          vy           <= cur_pt.y;
          last_vertex  <= hull_done;
          if (hull_done) begin
            state <= IDLE;
          end else begin
            cur     <= cand;
            cur_pt  <= cand_pt;
            emitted <= emitted_next;
            state   <= CAND_RD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* hdl/chgw_checker.sv */
module chgw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic last_point,
  input logic busy,
  input logic valid,
  input logic last_vertex
);

  // a plain load beat never starts a pass
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_point |=> !busy)
    else $error("busy after a load beat without last_point");

  // the final vertex ends the pass
  a_last_ends_pass: assert property (@(posedge clk) disable iff (rst)
    valid && last_vertex |-> !busy)
    else $error("still busy on the final vertex");

  // any other vertex is shown mid-pass
  a_mid_vertex_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last_vertex |-> busy)
    else $error("vertex beat outside a pass");

  // vertex beats are spaced by the scan loop
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("back-to-back vertex beats");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !busy && !valid)
    else $error("busy or valid after reset");

endmodule

bind convex_hull_gift_wrap chgw_checker u_chgw_checker (.*);

/* sim/hull_checker.sv */
module hull_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  chgw_pkg::coord_t           px,
  input  chgw_pkg::coord_t           py,
  input  logic                       last_point,
  input  logic                       valid,
  input  logic [chgw_pkg::IDX_W-1:0] vertex_index,
  input  chgw_pkg::coord_t           vx,
  input  chgw_pkg::coord_t           vy,
  input  logic                       last_vertex,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct {
    logic [chgw_pkg::IDX_W-1:0] idx;
    chgw_pkg::coord_t           x;
    chgw_pkg::coord_t           y;
    logic                       fin;
  } vertex_t;

  chgw_pkg::point_t pt_mem [MAX_POINTS];
  int               pt_cnt;
  int               set_n;
  vertex_t          hull_q [$];
  vertex_t          got_v;

  // c strictly left of directed line a->b
  function automatic bit left_of(int c, int a, int b);
    longint abx, aby, acx, acy;
    abx = longint'(pt_mem[b].x) - longint'(pt_mem[a].x);
    aby = longint'(pt_mem[b].y) - longint'(pt_mem[a].y);
    acx = longint'(pt_mem[c].x) - longint'(pt_mem[a].x);
    acy = longint'(pt_mem[c].y) - longint'(pt_mem[a].y);
    return (abx * acy - aby * acx) > 0;
  endfunction

  task automatic march_hull(int n);
    int      first, cur, cand, emitted;
    bit      done;
    vertex_t v;
    first = 0;
    for (int i = 1; i < n; i++)
      if (pt_mem[i].x < pt_mem[first].x) first = i;
    cur     = first;
    emitted = 0;
    done    = 0;
    while (!done) begin
      v.idx = cur[chgw_pkg::IDX_W-1:0];
      v.x   = pt_mem[cur].x;
      v.y   = pt_mem[cur].y;
      v.fin = 1'b0;
      emitted++;
      cand = (cur + 1) % n;
      for (int i = 0; i < n; i++)
        if (left_of(cur, i, cand)) cand = i;
      cur = cand;
      // degenerate sets may never close; cap the vertex count
      if (cur == first || emitted >= MAX_POINTS) begin
        v.fin = 1'b1;
        done  = 1;
      end
      hull_q.push_back(v);
    end
  endtask

  task automatic flag_mismatch(string field, longint expd, longint got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, expd, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pt_cnt = 0;
      hull_q.delete();
      outstanding <= 0;
    end else begin
      // results first: a new set cannot produce a vertex in its own beat
      if (valid) begin
        if (hull_q.size() == 0) begin
          mismatches++;
          $error("vertex beat with no hull vertex pending (index %0d)", vertex_index);
        end else begin
          got_v = hull_q.pop_front();
          if (vertex_index !== got_v.idx) flag_mismatch("vertex_index", got_v.idx, vertex_index);
          if (vx !== got_v.x)             flag_mismatch("vx", got_v.x, vx);
          if (vy !== got_v.y)             flag_mismatch("vy", got_v.y, vy);
          if (last_vertex !== got_v.fin)  flag_mismatch("last_vertex", got_v.fin, last_vertex);
        end
      end
      if (start && !busy) begin
        if (pt_cnt < MAX_POINTS) begin
          pt_mem[pt_cnt] = '{y: py, x: px};
          pt_cnt++;
        end
        if (last_point) begin
          set_n  = pt_cnt;
          pt_cnt = 0;
          if (set_n >= chgw_pkg::MIN_HULL_PTS) march_hull(set_n);
        end
      end
      outstanding <= hull_q.size();
    end
  end

endmodule

/* sim/tb_top.sv */
module tb_top;

  // how the coordinates of one point set are spread
  typedef enum {SPREAD_FULL, SPREAD_TIGHT, SPREAD_EDGE} spread_e;

  logic                       clk;
  logic                       rst;
  logic                       start;
  chgw_pkg::coord_t           px;
  chgw_pkg::coord_t           py;
  logic                       last_point;
  logic                       busy;
  logic                       valid;
  logic [chgw_pkg::IDX_W-1:0] vertex_index;
  chgw_pkg::coord_t           vx;
  chgw_pkg::coord_t           vy;
  logic                       last_vertex;
  int                         mismatches;
  int                         outstanding;

  bit               idle_ok;     // sender gaps allowed for the current set

  convex_hull_gift_wrap u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .px           (px),
    .py           (py),
    .last_point   (last_point),
    .busy         (busy),
    .valid        (valid),
    .vertex_index (vertex_index),
    .vx           (vx),
    .vy           (vy),
    .last_vertex  (last_vertex)
  );

  // watches both channels, predicts every hull vertex and compares
  hull_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .px           (px),
    .py           (py),
    .last_point   (last_point),
    .valid        (valid),
    .vertex_index (vertex_index),
    .vx           (vx),
    .vy           (vy),
    .last_vertex  (last_vertex),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop; worst legal run is far below this
  initial begin
    #3200000;
    $display("FAIL");
    $finish;
  end

  function automatic chgw_pkg::coord_t to_coord(int v);
    return chgw_pkg::coord_t'(v);
  endfunction

  // full range covers every bit of both coordinates; the tight box
  // piles up duplicates and collinear runs; edge values hit the extremes
  function automatic chgw_pkg::coord_t pick_coord(spread_e mode);
    case (mode)
      SPREAD_TIGHT: return chgw_pkg::coord_t'(int'($urandom_range(0, 6)) - 3);
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return chgw_pkg::coord_t'(-32768);
          1:       return chgw_pkg::coord_t'(32767);
          2:       return chgw_pkg::coord_t'(0);
          3:       return chgw_pkg::coord_t'(-1);
          default: return chgw_pkg::coord_t'($urandom);
        endcase
      end
      default:     return chgw_pkg::coord_t'($urandom);
    endcase
  endfunction

  // One point beat. start is only lowered for an idle burst, so it is
  // never dropped and raised in the same step.
  task automatic send_point(chgw_pkg::coord_t x, chgw_pkg::coord_t y, logic fin);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start      <= 1'b1;
    px         <= x;
    py         <= y;
    last_point <= fin;
    do @(posedge clk); while (busy);
  endtask

  // hold the sender until every predicted vertex has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stim
    int      rand_items;
    int      set_size;
    int      pick;
    bit      big_done;
    spread_e mode;

    rand_items = 0;
    big_done   = 0;
    idle_ok    = 1;
    start      <= 1'b0;
    px         <= '0;
    py         <= '0;
    last_point <= 1'b0;
    rst        <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // corners of the coordinate range
    send_point(to_coord(-32768), to_coord(-32768), 1'b0);
    send_point(to_coord(32767), to_coord(-32768), 1'b0);
    send_point(to_coord(32767), to_coord(32767), 1'b0);
    send_point(to_coord(-32768), to_coord(32767), 1'b1);
    // too few points: one, then two; no vertices, count clears
    send_point(to_coord(5), to_coord(5), 1'b1);
    send_point(to_coord(-5), to_coord(9), 1'b0);
    send_point(to_coord(7), to_coord(-2), 1'b1);
    // collinear triple; the middle point is kept as a hull vertex
    send_point(to_coord(0), to_coord(0), 1'b0);
    send_point(to_coord(5), to_coord(5), 1'b0);
    send_point(to_coord(10), to_coord(10), 1'b1);
    // tie on leftmost x; lowest index wins
    send_point(to_coord(-7), to_coord(3), 1'b0);
    send_point(to_coord(-7), to_coord(-3), 1'b0);
    send_point(to_coord(4), to_coord(0), 1'b1);
    // all duplicates
    send_point(to_coord(1), to_coord(1), 1'b0);
    send_point(to_coord(1), to_coord(1), 1'b0);
    send_point(to_coord(1), to_coord(1), 1'b1);
    // square with one interior point
    send_point(to_coord(0), to_coord(0), 1'b0);
    send_point(to_coord(10), to_coord(0), 1'b0);
    send_point(to_coord(0), to_coord(10), 1'b0);
    send_point(to_coord(2), to_coord(2), 1'b0);
    send_point(to_coord(10), to_coord(10), 1'b1);
    wait_drained();

    // Random sets: mostly well formed (3+ points), some short noise sets,
    // and once a set that overflows the store, last mark on a dropped point.
    while (rand_items < 105) begin
      if (!big_done && rand_items >= 20) begin
        set_size = 66;
        mode     = SPREAD_TIGHT;
        big_done = 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      set_size = $urandom_range(3, 12);
        else if (pick < 85) set_size = $urandom_range(1, 2);
        else                set_size = $urandom_range(13, 24);
        mode = spread_e'($urandom_range(0, 2));
      end
      // gaps in bursts per set, none in the tail of the run
      idle_ok = (rand_items <= 80) && ($urandom_range(0, 2) != 0);
      for (int k = 0; k < set_size; k++)
        send_point(pick_coord(mode), pick_coord(mode), k == set_size - 1);
      rand_items += set_size;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
